// File: design/sce_pkg.sv
`default_nettype none
package sce_pkg;

    localparam int MAX_CODE_LEN = 64;

    localparam int LEN_W  = 7;
    localparam int MSG_LEN_W = 6;
    localparam int POLY_W = 64;
    localparam int MSG_W  = 63;
    localparam int CW_W   = 64;
    localparam int PAR_W  = 63;
    localparam int STAT_W = 2;
    localparam int DEG_W  = 6;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_CODE_LEN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MSG_LEN  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GEN_POLY = 2'd2;

    localparam logic [LEN_W-1:0]     RST_CODE_LEN = 7'd7;
    localparam logic [MSG_LEN_W-1:0] RST_MSG_LEN  = 6'd4;
    localparam logic [POLY_W-1:0]    RST_GEN_POLY = 64'd11;

    localparam logic [STAT_W-1:0] STAT_OK     = 2'd0;
    localparam logic [STAT_W-1:0] STAT_DEGREE = 2'd1;
    localparam logic [STAT_W-1:0] STAT_NODIV  = 2'd2;
    localparam logic [STAT_W-1:0] STAT_LONG   = 2'd3;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_CHECK = 6'b000010,
        ST_POW   = 6'b000100,
        ST_PCHK  = 6'b001000,
        ST_DIV   = 6'b010000,
        ST_DONE  = 6'b100000
    } state_t;

endpackage
`default_nettype wire

// File: design/sce_div_step.sv
`default_nettype none
module sce_div_step (
    input  wire logic [sce_pkg::PAR_W-1:0]  rem_in,
    input  wire logic                       bit_in,
    input  wire logic [sce_pkg::DEG_W-1:0]  deg,
    input  wire logic [sce_pkg::POLY_W-1:0] gen,
    output logic      [sce_pkg::PAR_W-1:0]  rem_out
);

    logic [sce_pkg::POLY_W-1:0] shifted;

    always_comb
    begin
        shifted = {rem_in, 1'b0} ^ (sce_pkg::POLY_W'(bit_in) << deg);
        if (shifted[deg])
        begin
            shifted = shifted ^ gen;
        end
        rem_out = shifted[sce_pkg::PAR_W-1:0];
    end

endmodule
`default_nettype wire

// File: design/systematic_cyclic_encoder.sv
// channel  | handshake             | payload
// ---------+-----------------------+-------------------------------------
// input    | in_valid / in_ready   | message_word
// output   | out_valid / out_ready | codeword, parity_bits, status
// config   | cfg_we                | cfg_index, cfg_data
//
// A failed length, degree or message check skips both divisions, and an
// item whose g(x) does not divide x^l+1 ends before the parity division.
// The single GF(2) shift-and-reduce step runs once per cycle: l times for
// x^l mod g(x), then k times for the parity. rst_n clears the sequencer,
// the output valid and loads the default configuration. A stalled output
// holds its item; the next item is taken meanwhile and waits at the end.
`default_nettype none
module systematic_cyclic_encoder (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [sce_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [sce_pkg::POLY_W-1:0]    cfg_data,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [sce_pkg::MSG_W-1:0]     message_word,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic      [sce_pkg::CW_W-1:0]      codeword,
    output logic      [sce_pkg::PAR_W-1:0]     parity_bits,
    output logic      [sce_pkg::STAT_W-1:0]    status
);

    logic [sce_pkg::LEN_W-1:0]     code_len_reg;
    logic [sce_pkg::MSG_LEN_W-1:0] msg_len_reg;
    logic [sce_pkg::POLY_W-1:0]    gen_reg;

    sce_pkg::state_t               state_reg, state_next;
    logic [sce_pkg::MSG_W-1:0]     msg_reg, msg_next;
    logic [sce_pkg::PAR_W-1:0]     rem_reg, rem_next;
    logic [sce_pkg::LEN_W-1:0]     cnt_reg, cnt_next;
    logic [sce_pkg::DEG_W-1:0]     deg_reg, deg_next;
    logic [sce_pkg::STAT_W-1:0]    stat_reg, stat_next;

    logic                          out_valid_reg, out_valid_next;
    logic [sce_pkg::CW_W-1:0]      cw_reg, cw_next;
    logic [sce_pkg::PAR_W-1:0]     par_reg, par_next;
    logic [sce_pkg::STAT_W-1:0]    ostat_reg, ostat_next;

    logic [sce_pkg::DEG_W-1:0]     deg_calc;
    logic                          len_ok;
    logic                          deg_ok;
    logic                          msg_long;
    logic [sce_pkg::POLY_W-1:0]    gen_low_mask;
    logic [sce_pkg::MSG_W-1:0]     msg_low_mask;
    logic                          step_bit;
    logic [sce_pkg::PAR_W-1:0]     step_rem;
    logic                          out_free;

    sce_div_step u_step (
        .rem_in  (rem_reg),
        .bit_in  (step_bit),
        .deg     (deg_reg),
        .gen     (gen_reg),
        .rem_out (step_rem)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            code_len_reg <= sce_pkg::RST_CODE_LEN;
            msg_len_reg  <= sce_pkg::RST_MSG_LEN;
            gen_reg      <= sce_pkg::RST_GEN_POLY;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                sce_pkg::CFG_CODE_LEN: code_len_reg <= cfg_data[sce_pkg::LEN_W-1:0];
                sce_pkg::CFG_MSG_LEN:  msg_len_reg  <= cfg_data[sce_pkg::MSG_LEN_W-1:0];
                sce_pkg::CFG_GEN_POLY: gen_reg      <= cfg_data;
                default:               ;
            endcase
        end
    end

    assign deg_calc = sce_pkg::DEG_W'(code_len_reg - {1'b0, msg_len_reg});
    assign len_ok   = (code_len_reg >= sce_pkg::LEN_W'(2))
                   && (code_len_reg <= sce_pkg::LEN_W'(sce_pkg::MAX_CODE_LEN))
                   && (msg_len_reg != '0)
                   && ({1'b0, msg_len_reg} < code_len_reg);
    assign gen_low_mask = (sce_pkg::POLY_W'(2) << deg_calc) - sce_pkg::POLY_W'(1);
    assign deg_ok   = gen_reg[deg_calc] && ((gen_reg & ~gen_low_mask) == '0);
    assign msg_low_mask = sce_pkg::MSG_W'((sce_pkg::POLY_W'(1) << msg_len_reg)
                                          - sce_pkg::POLY_W'(1));
    assign msg_long = |(msg_reg & ~msg_low_mask);
    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next     = state_reg;
        msg_next       = msg_reg;
        rem_next       = rem_reg;
        cnt_next       = cnt_reg;
        deg_next       = deg_reg;
        stat_next      = stat_reg;
        out_valid_next = out_valid_reg;
        cw_next        = cw_reg;
        par_next       = par_reg;
        ostat_next     = ostat_reg;
        step_bit       = 1'b0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            sce_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    msg_next   = message_word;
                    state_next = sce_pkg::ST_CHECK;
                end
            end
            sce_pkg::ST_CHECK:
            begin
                deg_next = deg_calc;
                rem_next = sce_pkg::PAR_W'(1);
                cnt_next = code_len_reg;
                if (!len_ok || !deg_ok)
                begin
                    stat_next  = sce_pkg::STAT_DEGREE;
                    state_next = sce_pkg::ST_DONE;
                end
                else if (msg_long)
                begin
                    stat_next  = sce_pkg::STAT_LONG;
                    state_next = sce_pkg::ST_DONE;
                end
                else
                begin
                    stat_next  = sce_pkg::STAT_OK;
                    state_next = sce_pkg::ST_POW;
                end
            end
            sce_pkg::ST_POW:
            begin
                rem_next = step_rem;
                cnt_next = cnt_reg - sce_pkg::LEN_W'(1);
                if (cnt_reg == sce_pkg::LEN_W'(1))
                begin
                    state_next = sce_pkg::ST_PCHK;
                end
            end
            sce_pkg::ST_PCHK:
            begin
                rem_next = '0;
                cnt_next = {1'b0, msg_len_reg};
                if (rem_reg != sce_pkg::PAR_W'(1))
                begin
                    stat_next  = sce_pkg::STAT_NODIV;
                    state_next = sce_pkg::ST_DONE;
                end
                else
                begin
                    state_next = sce_pkg::ST_DIV;
                end
            end
            sce_pkg::ST_DIV:
            begin
                step_bit = msg_reg[sce_pkg::DEG_W'(cnt_reg - sce_pkg::LEN_W'(1))];
                rem_next = step_rem;
                cnt_next = cnt_reg - sce_pkg::LEN_W'(1);
                if (cnt_reg == sce_pkg::LEN_W'(1))
                begin
                    state_next = sce_pkg::ST_DONE;
                end
            end
            sce_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    ostat_next     = stat_reg;
                    if (stat_reg == sce_pkg::STAT_OK)
                    begin
                        par_next = rem_reg;
                        cw_next  = (sce_pkg::CW_W'(msg_reg) << deg_reg)
                                 | sce_pkg::CW_W'(rem_reg);
                    end
                    else
                    begin
                        par_next = '0;
                        cw_next  = '0;
                    end
                    state_next = sce_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = sce_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sce_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
            stat_reg      <= sce_pkg::STAT_OK;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            cnt_reg       <= cnt_next;
            stat_reg      <= stat_next;
        end
    end

    always_ff @(posedge clk)
    begin
        msg_reg   <= msg_next;
        rem_reg   <= rem_next;
        deg_reg   <= deg_next;
        cw_reg    <= cw_next;
        par_reg   <= par_next;
        ostat_reg <= ostat_next;
    end

    assign in_ready    = (state_reg == sce_pkg::ST_IDLE);
    assign out_valid   = out_valid_reg;
    assign codeword    = cw_reg;
    assign parity_bits = par_reg;
    assign status      = ostat_reg;

endmodule
`default_nettype wire

// File: design/sce_checker.sv
`default_nettype none
module sce_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          in_valid,
    input wire logic                          in_ready,
    input wire logic                          out_valid,
    input wire logic                          out_ready,
    input wire logic [sce_pkg::CW_W-1:0]      codeword,
    input wire logic [sce_pkg::PAR_W-1:0]     parity_bits,
    input wire logic [sce_pkg::STAT_W-1:0]    status
);

    // drop payload on any error
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != sce_pkg::STAT_OK)
        |-> (codeword == '0) && (parity_bits == '0))
        else $error("error item carries nonzero payload");

    // parity sits in the low bits of the codeword
    a_par_in_cw: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == sce_pkg::STAT_OK)
        |-> ((codeword[sce_pkg::PAR_W-1:0] & parity_bits) == parity_bits))
        else $error("parity not found in codeword");

    // one item at a time
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("item taken while busy");

    // hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready
        |=> out_valid && $stable(codeword) && $stable(parity_bits) && $stable(status))
        else $error("stalled result changed");

endmodule

bind systematic_cyclic_encoder sce_checker u_sce_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .codeword    (codeword),
    .parity_bits (parity_bits),
    .status      (status)
);
`default_nettype wire
